// ===== src/av_timestamp_jitter_corrector_assert.svh =====
// Assertion macros shared by the timestamp corrector modules.
// Each macro takes a label, the clock, the active-low reset and a property or condition.
`ifndef AV_TIMESTAMP_JITTER_CORRECTOR_ASSERT_SVH
`define AV_TIMESTAMP_JITTER_CORRECTOR_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property at every rising edge outside reset.
`define AVTJC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("avtjc assertion failed");

// Check that a condition never holds outside reset.
`define AVTJC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("avtjc forbidden condition seen");

`else

`define AVTJC_ASSERT(lbl, clk, rst_n, prop)
`define AVTJC_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== src/avtjc_pkg.sv =====
`timescale 1ns / 1ps

package avtjc_pkg;

    localparam int TS_W  = 64;
    localparam int REG_W = 31;
    localparam int IDX_W = 2;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_AUDIO_STEP = 2'd0;
    localparam logic [IDX_W-1:0] REG_VIDEO_STEP = 2'd1;
    localparam logic [IDX_W-1:0] REG_THRESHOLD  = 2'd2;

    // Reset values of the configuration registers
    localparam logic [REG_W-1:0] AUDIO_STEP_RST = 31'd23;
    localparam logic [REG_W-1:0] VIDEO_STEP_RST = 31'd66;
    localparam logic [REG_W-1:0] THRESHOLD_RST  = 31'd500;

    typedef logic [TS_W-1:0] t_ts;

    typedef struct packed {
        logic [REG_W-1:0] audio_step;
        logic [REG_W-1:0] video_step;
        logic [REG_W-1:0] threshold;
    } t_cfg;

endpackage

// ===== src/avtjc_cfg_regs.sv =====
`timescale 1ns / 1ps

module avtjc_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [avtjc_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [avtjc_pkg::REG_W-1:0]     i_cfg_wdata,
    output avtjc_pkg::t_cfg                 o_cfg
);

    avtjc_pkg::t_cfg r_cfg;

    // Write the addressed register; drop writes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.audio_step <= avtjc_pkg::AUDIO_STEP_RST;
            r_cfg.video_step <= avtjc_pkg::VIDEO_STEP_RST;
            r_cfg.threshold  <= avtjc_pkg::THRESHOLD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                avtjc_pkg::REG_AUDIO_STEP: r_cfg.audio_step <= i_cfg_wdata;
                avtjc_pkg::REG_VIDEO_STEP: r_cfg.video_step <= i_cfg_wdata;
                avtjc_pkg::REG_THRESHOLD:  r_cfg.threshold  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/avtjc_core.sv =====
`timescale 1ns / 1ps
`include "av_timestamp_jitter_corrector_assert.svh"

module avtjc_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic                i_is_video,
    input  avtjc_pkg::t_ts      i_ts,
    input  avtjc_pkg::t_cfg     i_cfg,
    output avtjc_pkg::t_ts      o_result
);

    logic           r_seen_first;
    avtjc_pkg::t_ts r_prev_in;
    avtjc_pkg::t_ts r_prev_out;
    avtjc_pkg::t_ts r_prev_audio;
    avtjc_pkg::t_ts r_prev_video;

    avtjc_pkg::t_ts w_step;
    avtjc_pkg::t_ts w_cand;
    avtjc_pkg::t_ts w_thr;
    logic           w_jump;

    // Raw step from the previous input; a jump is negative or at/above threshold
    assign w_thr  = {{(avtjc_pkg::TS_W-avtjc_pkg::REG_W){1'b0}}, i_cfg.threshold};
    assign w_step = i_ts - r_prev_in;
    assign w_jump = w_step[avtjc_pkg::TS_W-1] || (w_step >= w_thr);

    // Candidate from the same stream's history plus its frame duration
    always_comb begin
        if (i_is_video) begin
            w_cand = r_prev_video
                   + {{(avtjc_pkg::TS_W-avtjc_pkg::REG_W){1'b0}}, i_cfg.video_step};
        end else begin
            w_cand = r_prev_audio
                   + {{(avtjc_pkg::TS_W-avtjc_pkg::REG_W){1'b0}}, i_cfg.audio_step};
        end
    end

    // Zero first, last output plus step, or on a jump the clamped candidate
    always_comb begin
        priority if (!r_seen_first) begin
            o_result = '0;
        end else if (!w_jump) begin
            o_result = r_prev_out + w_step;
        end else if (w_cand < r_prev_out) begin
            o_result = r_prev_out;
        end else begin
            o_result = w_cand;
        end
    end

    // Update the histories on every processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_first <= 1'b0;
            r_prev_in    <= '0;
            r_prev_out   <= '0;
            r_prev_audio <= '0;
            r_prev_video <= '0;
        end else if (i_fire) begin
            r_seen_first <= 1'b1;
            r_prev_in    <= i_ts;
            r_prev_out   <= o_result;
            if (!r_seen_first) begin
                r_prev_audio <= '0;
                r_prev_video <= '0;
            end else if (i_is_video) begin
                r_prev_video <= o_result;
            end else begin
                r_prev_audio <= o_result;
            end
        end
    end

    `AVTJC_ASSERT(a_first_is_zero, i_clk, i_rst_n, i_fire && !r_seen_first |-> o_result == '0)
    `AVTJC_ASSERT(a_jump_monotonic, i_clk, i_rst_n, i_fire && r_seen_first && w_jump |-> o_result >= r_prev_out)
    `AVTJC_ASSERT(a_seen_after_fire, i_clk, i_rst_n, i_fire |=> r_seen_first)

endmodule

// ===== src/av_timestamp_jitter_corrector.sv =====
`timescale 1ns / 1ps
`include "av_timestamp_jitter_corrector_assert.svh"
// Channel   | Direction | Handshake            | Payload
// s_axis    | in        | tvalid / tready      | tdata: in_timestamp; tuser: is_video
// m_axis    | out       | tvalid / tready      | tdata: out_timestamp
// cfg       | in        | we (no ready)        | idx 0 audio, 1 video, 2 threshold
//
// One item per cycle unless the output stalls: input register, one pass of adders and
// compares against the stream histories, then the result register.
// The histories update in the same cycle as the compute, so items follow back to back.
// Synchronous active-low reset clears histories and loads configuration defaults.
// An output stall holds the result register and then the input register; s_axis
// tready drops only when both are full and the output is not taken.

module av_timestamp_jitter_corrector (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [avtjc_pkg::TS_W-1:0]     i_s_axis_tdata,   // [63:0] in_timestamp
    input  logic                           i_s_axis_tuser,   // [0] is_video
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [avtjc_pkg::TS_W-1:0]     o_m_axis_tdata,   // [63:0] out_timestamp
    input  logic                           i_cfg_we,
    input  logic [avtjc_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [avtjc_pkg::REG_W-1:0]    i_cfg_wdata
);

    logic            r_s1_valid;
    logic            r_s1_is_video;
    avtjc_pkg::t_ts  r_s1_ts;
    logic            r_out_valid;
    avtjc_pkg::t_ts  r_out_ts;

    avtjc_pkg::t_cfg w_cfg;
    avtjc_pkg::t_ts  w_result;
    logic            w_s2_take;
    logic            w_fire;
    logic            w_in_acc;

    // Handshake between stages
    assign w_s2_take       = !r_out_valid || i_m_axis_tready;
    assign w_fire          = r_s1_valid && w_s2_take;
    assign o_s_axis_tready = !r_s1_valid || w_s2_take;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    avtjc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    avtjc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_fire),
        .i_is_video (r_s1_is_video),
        .i_ts       (r_s1_ts),
        .i_cfg      (w_cfg),
        .o_result   (w_result)
    );

    // Input register: load on accept, drop once processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_is_video <= i_s_axis_tuser;
            r_s1_ts       <= i_s_axis_tdata;
        end
    end

    // Result register: load on process, clear when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_ts <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_ts;

    `AVTJC_ASSERT(a_fire_fills_out, i_clk, i_rst_n, w_fire |=> r_out_valid)
    `AVTJC_ASSERT(a_s1_holds, i_clk, i_rst_n, r_s1_valid && !w_s2_take |=> r_s1_valid)
    `AVTJC_ASSERT_NEVER(a_stall_only_full, i_clk, i_rst_n, !o_s_axis_tready && !(r_s1_valid && r_out_valid))

endmodule
